// ===== hw/rtl/copg_pkg.sv =====
`default_nettype none

package copg_pkg;

    // fixed field widths
    localparam int COORD_BITS  = 16;
    localparam int RADIUS_BITS = 14;
    localparam int COLOR_BITS  = 32;
    localparam int STEP_BITS   = 15;
    localparam int ERR_BITS    = 20;
    localparam int PIX_IDX_BITS = 3;

    // error term constants
    localparam logic [ERR_BITS-1:0] ERR_DIFF_INIT = ERR_BITS'(3);
    localparam logic [ERR_BITS-1:0] ERR_STEP_INC  = ERR_BITS'(2);

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // input item
    typedef struct packed {
        logic                          cmd;
        logic signed [COORD_BITS-1:0]  center_x;
        logic signed [COORD_BITS-1:0]  center_y;
        logic        [RADIUS_BITS-1:0] radius;
        logic        [COLOR_BITS-1:0]  color;
    } copg_in_t;

    // result item
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic        [COLOR_BITS-1:0] pixel_color;
        logic                         run_last;
        logic                         circle_done;
    } copg_out_t;

    // one burst of pixels handed from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COLOR_BITS-1:0] color;
        logic [STEP_BITS-1:0]  p;
        logic [STEP_BITS-1:0]  q;
        logic                  is_start;
        logic                  eight;
        logic                  done;
    } copg_job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/copg_front.sv =====
`default_nettype none

module copg_front
    import copg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire copg_in_t  item,
    input  wire logic      job_full,
    output logic           job_push,
    output copg_job_t      job
);

    logic                  active_reg, active_next;
    logic [COORD_BITS-1:0] hold_cx_reg, hold_cx_next;
    logic [COORD_BITS-1:0] hold_cy_reg, hold_cy_next;
    logic [COLOR_BITS-1:0] hold_color_reg, hold_color_next;
    logic [STEP_BITS-1:0]  dx_reg, dx_next;
    logic [STEP_BITS-1:0]  dy_reg, dy_next;
    logic [ERR_BITS-1:0]   off_reg, off_next;
    logic [ERR_BITS-1:0]   term_reg, term_next;
    logic [ERR_BITS-1:0]   diff_reg, diff_next;

    logic                  accept;
    logic [ERR_BITS-1:0]   off_sum;
    logic [ERR_BITS-1:0]   off_tmp;
    logic                  take;
    logic [STEP_BITS-1:0]  dy_step;
    logic [STEP_BITS-1:0]  dx_inc;
    logic                  step_done;
    logic                  start_done;

    // magnitude of a two's complement error value, as unsigned
    function automatic logic [ERR_BITS-1:0] err_mag(input logic [ERR_BITS-1:0] v);
        err_mag = v[ERR_BITS-1] ? (~v + ERR_BITS'(1)) : v;
    endfunction

    assign accept = push && !job_full;

    // midpoint error update for one step
    assign off_sum    = off_reg + diff_reg;
    assign off_tmp    = off_sum + term_reg;
    assign take       = err_mag(off_tmp) < err_mag(off_sum);
    assign dy_step    = take ? (dy_reg - STEP_BITS'(1)) : dy_reg;
    assign dx_inc     = dx_reg + STEP_BITS'(1);
    assign step_done  = !(dx_inc < dy_step);
    assign start_done = !(item.radius > RADIUS_BITS'(1));

    // next state and job build
    always_comb
    begin
        active_next     = active_reg;
        hold_cx_next    = hold_cx_reg;
        hold_cy_next    = hold_cy_reg;
        hold_color_next = hold_color_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        off_next        = off_reg;
        term_next       = term_reg;
        diff_next       = diff_reg;
        job_push        = 1'b0;

        job.cx       = hold_cx_reg;
        job.cy       = hold_cy_reg;
        job.color    = hold_color_reg;
        job.p        = dx_reg;
        job.q        = dy_step;
        job.is_start = 1'b0;
        job.eight    = (dx_reg != dy_step);
        job.done     = step_done;

        if (item.cmd == CMD_START)
        begin
            job.cx       = item.center_x;
            job.cy       = item.center_y;
            job.color    = item.color;
            job.p        = STEP_BITS'(item.radius);
            job.q        = STEP_BITS'(item.radius);
            job.is_start = 1'b1;
            job.eight    = 1'b0;
            job.done     = start_done;
            if (accept)
            begin
                job_push        = 1'b1;
                hold_cx_next    = item.center_x;
                hold_cy_next    = item.center_y;
                hold_color_next = item.color;
                off_next        = '0;
                diff_next       = ERR_DIFF_INIT;
                term_next       = ERR_DIFF_INIT - (ERR_BITS'(item.radius) << 1);
                dx_next         = STEP_BITS'(1);
                dy_next         = STEP_BITS'(item.radius);
                active_next     = !start_done;
            end
        end
        else if (accept && active_reg)
        begin
            job_push    = 1'b1;
            off_next    = take ? off_tmp : off_sum;
            term_next   = take ? (term_reg + ERR_STEP_INC) : term_reg;
            diff_next   = diff_reg + ERR_STEP_INC;
            dy_next     = dy_step;
            dx_next     = dx_inc;
            active_next = !step_done;
        end
    end

    // circle state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            hold_cx_reg    <= '0;
            hold_cy_reg    <= '0;
            hold_color_reg <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            off_reg        <= '0;
            term_reg       <= '0;
            diff_reg       <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            hold_cx_reg    <= hold_cx_next;
            hold_cy_reg    <= hold_cy_next;
            hold_color_reg <= hold_color_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            off_reg        <= off_next;
            term_reg       <= term_next;
            diff_reg       <= diff_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/copg_queue.sv =====
`default_nettype none

module copg_queue
    import copg_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr,
    input  wire copg_job_t wr_data,
    output logic           full,
    input  wire logic      rd,
    output copg_job_t      rd_data,
    output logic           empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    copg_job_t             entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/copg_back.sv =====
`default_nettype none

module copg_back
    import copg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire copg_job_t job,
    input  wire logic      job_empty,
    output logic           job_pop,
    input  wire logic      pop,
    output logic           empty,
    output copg_out_t      result
);

    logic [PIX_IDX_BITS-1:0] idx_reg, idx_next;
    logic                    valid_reg, valid_next;
    copg_out_t               out_reg, out_next;

    logic                    advance;
    logic                    last;
    logic [COORD_BITS-1:0]   ox;
    logic [COORD_BITS-1:0]   oy;
    logic                    neg_x;
    logic                    neg_y;

    assign advance = !valid_reg || pop;
    assign last    = job.eight ? (idx_reg == PIX_IDX_BITS'(7)) : (idx_reg == PIX_IDX_BITS'(3));
    assign empty   = !valid_reg;
    assign result  = out_reg;

    // offset and mirror selection for the current pixel
    always_comb
    begin
        ox    = COORD_BITS'(job.p);
        oy    = COORD_BITS'(job.q);
        neg_x = idx_reg[1];
        neg_y = idx_reg[0];
        if (job.is_start)
        begin
            case (idx_reg[1:0])
                2'd0:
                begin
                    ox = '0;
                    neg_x = 1'b0;
                    neg_y = 1'b0;
                end
                2'd1:
                begin
                    ox = '0;
                    neg_x = 1'b0;
                    neg_y = 1'b1;
                end
                2'd2:
                begin
                    oy = '0;
                    neg_x = 1'b0;
                    neg_y = 1'b0;
                end
                default:
                begin
                    oy = '0;
                    neg_x = 1'b1;
                    neg_y = 1'b0;
                end
            endcase
        end
        else if (idx_reg[2])
        begin
            ox = COORD_BITS'(job.q);
            oy = COORD_BITS'(job.p);
        end
    end

    // output register and pixel counter
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        job_pop    = 1'b0;
        if (advance)
        begin
            valid_next = !job_empty;
            if (!job_empty)
            begin
                out_next.pixel_x     = neg_x ? (job.cx - ox) : (job.cx + ox);
                out_next.pixel_y     = neg_y ? (job.cy - oy) : (job.cy + oy);
                out_next.pixel_color = job.color;
                out_next.run_last    = last;
                out_next.circle_done = job.done;
                job_pop              = last;
                idx_next             = last ? '0 : idx_reg + PIX_IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/circle_outline_pixel_generator.sv =====
// circle outline pixel generator, midpoint scheme with eight-way symmetry
//
// input side is a queue: an item transfers when push is high and full is low.
// cmd start loads centre, radius and colour and yields the four axis pixels;
// cmd step advances one octant position and yields eight mirrored pixels, or
// four on the diagonal. a step with no circle in progress yields nothing.
// result side is a queue: the oldest pixel sits on result while empty is low
// and transfers when pop is high. run_last marks the final pixel of an item,
// circle_done is set on every pixel of the item that finishes the circle.
//
// the front updates the error terms for each accepted item and posts a burst
// descriptor into a QUEUE_DEPTH-entry queue; the back expands it one pixel
// per cycle, while the receiver keeps popping, into the output register. an
// item passes a queue entry and then the output register before its first
// pixel appears. a stalled receiver holds the pixel; the queue keeps taking
// items until full. reset clears the circle state, the queue pointers and the
// output valid flag; the pixel payload itself is not reset.
`default_nettype none

module circle_outline_pixel_generator
    import copg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire copg_in_t item,
    output logic          empty,
    input  wire logic     pop,
    output copg_out_t     result
);

    copg_job_t job_in;
    copg_job_t job_out;
    logic      job_push;
    logic      job_pop;
    logic      job_full;
    logic      job_empty;

    assign full = job_full;

    // item classification and error update
    copg_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in)
    );

    // burst queue between front and back
    copg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd      (job_pop),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    // pixel expansion
    copg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== tb/tb_circle_outline_pixel_generator.sv =====
`default_nettype none

module tb_circle_outline_pixel_generator;
    import copg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // command still waiting to be offered, optionally held back until the pipe drains
    typedef struct {
        copg_in_t word;
        bit       hold_for_drain;
    } pending_cmd_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    copg_in_t  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    copg_out_t result;

    pending_cmd_t cmd_queue[$];
    copg_out_t    pixel_queue[$];
    int           fail_count = 0;
    int           send_gap = 0;
    int           stall_left = 0;

    // circle state as the block should hold it
    logic               circ_busy = 1'b0;
    logic [15:0]        circ_cx = '0;
    logic [15:0]        circ_cy = '0;
    logic [31:0]        circ_color = '0;
    logic [14:0]        circ_dx = '0;
    logic [14:0]        circ_dy = '0;
    logic signed [19:0] circ_off = '0;
    logic signed [19:0] circ_term = '0;
    logic signed [19:0] circ_diff = '0;

    circle_outline_pixel_generator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic copg_out_t make_pixel(input logic [15:0] x, input logic [15:0] y);
        copg_out_t p;
        p.pixel_x     = x;
        p.pixel_y     = y;
        p.pixel_color = circ_color;
        p.run_last    = 1'b0;
        p.circle_done = 1'b0;
        return p;
    endfunction

    // expected pixels of one transferred command, advancing the circle state
    task automatic trace_circle_item(input copg_in_t it);
        copg_out_t          batch[$];
        logic signed [19:0] off_n;
        logic signed [19:0] trial;
        logic [15:0]        r16;
        logic [15:0]        dx16;
        logic [15:0]        dy16;
        int                 mag_trial;
        int                 mag_off;
        if (it.cmd == CMD_START)
        begin
            circ_cx    = it.center_x;
            circ_cy    = it.center_y;
            circ_color = it.color;
            r16        = 16'(it.radius);
            batch.push_back(make_pixel(circ_cx, circ_cy + r16));
            batch.push_back(make_pixel(circ_cx, circ_cy - r16));
            batch.push_back(make_pixel(circ_cx + r16, circ_cy));
            batch.push_back(make_pixel(circ_cx - r16, circ_cy));
            circ_off  = '0;
            circ_diff = ERR_DIFF_INIT;
            circ_term = 20'(int'(ERR_DIFF_INIT) - 2 * int'(it.radius));
            circ_dx   = 15'd1;
            circ_dy   = 15'(it.radius);
            circ_busy = it.radius > 1;
        end
        else if (circ_busy)
        begin
            // midpoint error update, taking the diagonal move when it gets closer
            off_n     = circ_off + circ_diff;
            trial     = off_n + circ_term;
            mag_trial = (trial < 0) ? -int'(trial) : int'(trial);
            mag_off   = (off_n < 0) ? -int'(off_n) : int'(off_n);
            if (mag_trial < mag_off)
            begin
                off_n     = trial;
                circ_term = circ_term + ERR_STEP_INC;
                circ_dy   = circ_dy - 15'd1;
            end
            circ_off  = off_n;
            circ_diff = circ_diff + ERR_STEP_INC;
            dx16 = 16'(circ_dx);
            dy16 = 16'(circ_dy);
            batch.push_back(make_pixel(circ_cx + dx16, circ_cy + dy16));
            batch.push_back(make_pixel(circ_cx + dx16, circ_cy - dy16));
            batch.push_back(make_pixel(circ_cx - dx16, circ_cy + dy16));
            batch.push_back(make_pixel(circ_cx - dx16, circ_cy - dy16));
            // off the diagonal the mirrored octant adds four more
            if (circ_dx != circ_dy)
            begin
                batch.push_back(make_pixel(circ_cx + dy16, circ_cy + dx16));
                batch.push_back(make_pixel(circ_cx + dy16, circ_cy - dx16));
                batch.push_back(make_pixel(circ_cx - dy16, circ_cy + dx16));
                batch.push_back(make_pixel(circ_cx - dy16, circ_cy - dx16));
            end
            circ_dx = circ_dx + 15'd1;
            if (!(circ_dx < circ_dy))
                circ_busy = 1'b0;
        end
        // flags on the finished batch
        foreach (batch[k])
        begin
            batch[k].circle_done = !circ_busy;
            batch[k].run_last    = (k == batch.size() - 1);
            pixel_queue.push_back(batch[k]);
        end
    endtask

    // compare one transferred pixel with the oldest expectation
    task automatic check_pixel(input copg_out_t got);
        copg_out_t want;
        if (pixel_queue.size() == 0)
        begin
            $error("unexpected pixel x %0d y %0d", got.pixel_x, got.pixel_y);
            fail_count++;
        end
        else
        begin
            want = pixel_queue.pop_front();
            if (got.pixel_x !== want.pixel_x)
            begin
                $error("pixel_x expected %0d actual %0d", want.pixel_x, got.pixel_x);
                fail_count++;
            end
            if (got.pixel_y !== want.pixel_y)
            begin
                $error("pixel_y expected %0d actual %0d", want.pixel_y, got.pixel_y);
                fail_count++;
            end
            if (got.pixel_color !== want.pixel_color)
            begin
                $error("pixel_color expected %h actual %h", want.pixel_color, got.pixel_color);
                fail_count++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last expected %b actual %b", want.run_last, got.run_last);
                fail_count++;
            end
            if (got.circle_done !== want.circle_done)
            begin
                $error("circle_done expected %b actual %b", want.circle_done, got.circle_done);
                fail_count++;
            end
        end
    endtask

    task automatic queue_cmd(input logic cmd, input logic [15:0] cx, input logic [15:0] cy,
                             input logic [13:0] r, input logic [31:0] color, input bit drain);
        pending_cmd_t c;
        c.word.cmd      = cmd;
        c.word.center_x = cx;
        c.word.center_y = cy;
        c.word.radius   = r;
        c.word.color    = color;
        c.hold_for_drain = drain;
        cmd_queue.push_back(c);
    endtask

    // step with random, ignored payload
    task automatic queue_step();
        queue_cmd(CMD_STEP, 16'($urandom), 16'($urandom), 14'($urandom), $urandom, 1'b0);
    endtask

    // sender: offers queued commands, predicts on each transfer, idles in bursts
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        copg_in_t next_item;
        logic     next_push;
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
            send_gap = 0;
        end
        else
        begin
            next_push = push;
            next_item = item;
            if (push && !full)
            begin
                trace_circle_item(item);
                next_push = 1'b0;
                if (cmd_queue.size() >= 12 && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 15);
            end
            if (!next_push)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (cmd_queue.size() != 0 &&
                         !(cmd_queue[0].hold_for_drain && pixel_queue.size() != 0))
                begin
                    next_item = cmd_queue[0].word;
                    void'(cmd_queue.pop_front());
                    next_push = 1'b1;
                end
            end
            push <= next_push;
            item <= next_item;
        end
    end

    // receiver: checks each transferred pixel, stalls in bursts
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        logic next_pop;
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (pop && !empty)
                check_pixel(result);
            if (stall_left > 0)
            begin
                stall_left--;
                next_pop = 1'b0;
            end
            else
            begin
                next_pop = 1'b1;
                if (cmd_queue.size() >= 12 && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 15);
            end
            pop <= next_pop;
        end
    end

    // stimulus, reset and verdict
    initial
    begin : stim_proc
        int n_items;
        int r;
        int n_steps;
        int roll;
        // directed: idle step, zero radius at the coordinate extremes, unit radius at the origin
        queue_step();
        queue_cmd(CMD_START, 16'h7fff, 16'h8000, 14'd0, 32'hffff_ffff, 1'b0);
        queue_cmd(CMD_START, 16'h8000, 16'h7fff, 14'd0, 32'h0000_0000, 1'b0);
        queue_cmd(CMD_START, 16'h0000, 16'h0000, 14'd1, 32'h5a5a_a5a5, 1'b0);
        queue_step();
        // largest radius with wrapping coordinates, after a full drain
        queue_cmd(CMD_START, 16'h8000, 16'h7fff, 14'h3fff, $urandom, 1'b1);
        repeat (3) queue_step();
        // restart while a circle is in progress
        queue_cmd(CMD_START, 16'd100, -16'sd100, 14'd5, 32'h1234_5678, 1'b0);
        repeat (5) queue_step();
        // radius two lands on the diagonal at once
        queue_cmd(CMD_START, 16'd7, 16'd9, 14'd2, 32'hdead_beef, 1'b0);
        queue_step();
        queue_cmd(CMD_START, -16'sd3, 16'd3, 14'd3, 32'h0f0f_0f0f, 1'b0);
        repeat (3) queue_step();
        queue_cmd(CMD_START, 16'h7fff, 16'h8000, 14'h3fff, $urandom, 1'b0);
        repeat (2) queue_step();

        // random: mostly whole small circles, some large or abandoned ones, some noise
        n_items = 0;
        while (n_items < 90)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
            begin
                queue_step();
                n_items += 1;
            end
            else if (roll == 1)
            begin
                n_steps = $urandom_range(0, 4);
                queue_cmd(CMD_START, 16'($urandom), 16'($urandom),
                          14'($urandom_range(0, 16383)), $urandom, 1'b0);
                repeat (n_steps) queue_step();
                n_items += 1 + n_steps;
            end
            else
            begin
                r = $urandom_range(0, 30);
                n_steps = r * 707 / 1000 + $urandom_range(0, 1);
                if ($urandom_range(0, 4) == 0)
                    n_steps = $urandom_range(0, n_steps);
                queue_cmd(CMD_START, 16'($urandom), 16'($urandom), 14'(r), $urandom,
                          $urandom_range(0, 5) == 0);
                repeat (n_steps) queue_step();
                n_items += 1 + n_steps;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // all commands transferred, then all pixels back
        while (cmd_queue.size() != 0 || push)
            @(posedge clk);
        for (int i = 0; i < 2000 && pixel_queue.size() != 0; i++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pixel_queue.size() != 0)
        begin
            $error("%0d expected pixels never arrived", pixel_queue.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
